// File: rtl/rip_pkg.sv
// ----------------------------------------------------------------------------
// rip_pkg: shared types and constants of the range image projector
// Item and result records, status codes, state encodings, CORDIC angle table.
// ----------------------------------------------------------------------------
package rip_pkg;

   localparam int COORD_W = 24;
   localparam int RANGE_W = 24;
   localparam int INTEN_W = 16;
   localparam int RING_W  = 8;
   localparam int INDEX_W = 15;
   localparam int DATA_W  = RANGE_W + 3 * COORD_W + INTEN_W;

   localparam int CORDIC_W = 48;
   localparam int ANG_W    = 35;
   localparam int T_W      = 48;
   localparam logic [4:0] CORDIC_LAST = 5'd29;
   localparam logic [4:0] ROOT_LAST   = 5'd25;
   localparam logic [4:0] REM_STEPS   = 5'd8;

   localparam logic KIND_PROJECT = 1'b0;
   localparam logic KIND_DRAIN   = 1'b1;

   localparam logic [1:0] CSR_MIN_RANGE = 2'd0;
   localparam logic [1:0] CSR_MAX_RANGE = 2'd1;
   localparam logic [1:0] CSR_DOWNSAMPLE = 2'd2;

   typedef enum logic [2:0] {
      ST_STORED  = 3'd0,
      ST_RANGE   = 3'd1,
      ST_RING    = 3'd2,
      ST_DOWNS   = 3'd3,
      ST_COLUMN  = 3'd4,
      ST_DUP     = 3'd5,
      ST_EXTRACT = 3'd6,
      ST_DONE    = 3'd7
   } rip_status_type;

   typedef struct packed {
      logic                       kind;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic signed [COORD_W-1:0]  z;
      logic [INTEN_W-1:0]         intensity;
      logic [RING_W-1:0]          ring;
      logic [RANGE_W-1:0]         range;
      rip_status_type             status;
   } rip_item_type;

   typedef struct packed {
      rip_status_type             status;
      logic [3:0]                 row;
      logic [9:0]                 column;
      logic [RANGE_W-1:0]         range;
      logic [COORD_W-1:0]         out_x;
      logic [COORD_W-1:0]         out_y;
      logic [COORD_W-1:0]         out_z;
      logic [INTEN_W-1:0]         out_intensity;
      logic [INDEX_W-1:0]         out_index;
      logic [INDEX_W-1:0]         ring_start_index;
      logic                       last;
   } rip_result_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_SQUARE,
      FR_ROOT,
      FR_EMIT
   } rip_front_state_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_ROTATE,
      BK_CORDIC,
      BK_SCALE,
      BK_COLUMN,
      BK_LOOKUP,
      BK_CHECK,
      BK_SCAN,
      BK_SCAN_CHK,
      BK_SEND
   } rip_back_state_type;

   // atan(2^-i) in 2^-32 turn
   function automatic logic [29:0] ang_step(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         5'd24: v = 30'd41;
         5'd25: v = 30'd20;
         5'd26: v = 30'd10;
         5'd27: v = 30'd5;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/rip_front.sv
// ----------------------------------------------------------------------------
// rip_front: intake and classification
// Squares and sums the coordinates, takes the integer root one bit a beat,
// works out ring mod rate, then tags the beat with its reject status.
// ----------------------------------------------------------------------------
module rip_front
   import rip_pkg::*;
#(
   parameter int ROWS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic signed [COORD_W-1:0] req_x,
   input  logic signed [COORD_W-1:0] req_y,
   input  logic signed [COORD_W-1:0] req_z,
   input  logic [INTEN_W-1:0]        req_intensity,
   input  logic [RING_W-1:0]         req_ring,
   input  logic [RANGE_W-1:0]        min_range,
   input  logic [RANGE_W-1:0]        max_range,
   input  logic [4:0]                downsample_rate,
   output logic                      push_valid,
   output rip_item_type              push_item,
   input  logic                      queue_full
);

   localparam logic [8:0] ROWS_LIM = 9'(ROWS);

   rip_front_state_type state_ff, state_in;

   logic                      kind_ff, kind_in;
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [INTEN_W-1:0]        inten_ff, inten_in;
   logic [RING_W-1:0]         ring_ff, ring_in;
   logic [1:0]                cnt_ff, cnt_in;
   logic [47:0]               prod_ff, prod_in;
   logic [49:0]               acc_ff, acc_in;
   logic [50:0]               s_ff, s_in, root_ff, root_in, bit_ff, bit_in;
   logic [4:0]                it_ff, it_in;
   logic [4:0]                rem_ff, rem_in;

   logic signed [COORD_W-1:0] sel_coord;
   logic [COORD_W-1:0]        sel_abs;
   logic [50:0]               root_try;
   logic [4:0]                divisor;
   logic [5:0]                rem_shift;
   logic [RANGE_W-1:0]        range_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      inten_ff <= inten_in;
      ring_ff  <= ring_in;
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      s_ff     <= s_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      it_ff    <= it_in;
      rem_ff   <= rem_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: begin
            if (req_valid) begin
               state_in = (req_kind == KIND_DRAIN) ? FR_EMIT : FR_SQUARE;
            end
         end
         FR_SQUARE: begin
            if (cnt_ff == 2'd3) begin
               state_in = FR_ROOT;
            end
         end
         FR_ROOT: begin
            if (it_ff == ROOT_LAST) begin
               state_in = FR_EMIT;
            end
         end
         FR_EMIT: begin
            if (!queue_full) begin
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      kind_in  = kind_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      inten_in = inten_ff;
      ring_in  = ring_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      s_in     = s_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      it_in    = it_ff;
      rem_in   = rem_ff;

      case (cnt_ff)
         2'd0:    sel_coord = x_ff;
         2'd1:    sel_coord = y_ff;
         default: sel_coord = z_ff;
      endcase
      sel_abs   = sel_coord[COORD_W-1] ? (~sel_coord + 1'b1) : sel_coord;
      root_try  = root_ff + bit_ff;
      divisor   = (downsample_rate == 5'd0) ? 5'd1 : downsample_rate;
      rem_shift = {rem_ff, ring_ff[3'd7 - it_ff[2:0]]};

      case (state_ff)
         FR_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               x_in     = req_x;
               y_in     = req_y;
               z_in     = req_z;
               inten_in = req_intensity;
               ring_in  = req_ring;
               cnt_in   = 2'd0;
            end
         end
         FR_SQUARE: begin
            prod_in = 48'(sel_abs) * 48'(sel_abs);
            cnt_in  = cnt_ff + 2'd1;
            case (cnt_ff)
               2'd0:    acc_in = '0;
               2'd3: begin
                  s_in    = 51'(acc_ff) + 51'(prod_ff);
                  root_in = '0;
                  bit_in  = 51'(1) << 50;
                  it_in   = 5'd0;
                  rem_in  = 5'd0;
               end
               default: acc_in = acc_ff + 50'(prod_ff);
            endcase
         end
         FR_ROOT: begin
            if (s_ff >= root_try) begin
               s_in    = s_ff - root_try;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            it_in  = it_ff + 5'd1;
            // ring mod rate, restoring, MSB first
            if (it_ff < REM_STEPS) begin
               rem_in = (rem_shift >= {1'b0, divisor}) ?
                        5'(rem_shift - {1'b0, divisor}) : 5'(rem_shift);
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      range_val  = root_ff[RANGE_W-1:0];
      req_ready  = (state_ff == FR_IDLE);
      push_valid = (state_ff == FR_EMIT);

      push_item.kind      = kind_ff;
      push_item.x         = x_ff;
      push_item.y         = y_ff;
      push_item.z         = z_ff;
      push_item.intensity = inten_ff;
      push_item.ring      = ring_ff;
      push_item.range     = range_val;

      if (kind_ff == KIND_DRAIN) begin
         push_item.status = ST_STORED;
      end else if (range_val < min_range || range_val > max_range) begin
         push_item.status = ST_RANGE;
      end else if ({1'b0, ring_ff} >= ROWS_LIM) begin
         push_item.status = ST_RING;
      end else if (rem_ff != 5'd0) begin
         push_item.status = ST_DOWNS;
      end else begin
         push_item.status = ST_STORED;
      end
   end

endmodule

// File: rtl/rip_queue.sv
// ----------------------------------------------------------------------------
// rip_queue: two-entry queue between intake and back end
// Lets the front classify the next point while the back end works.
// ----------------------------------------------------------------------------
module rip_queue
   import rip_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  rip_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output rip_item_type head
);

   rip_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_comb begin
      full      = (count_ff == 2'd2);
      empty     = (count_ff == 2'd0);
      do_push   = push_valid && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
      head      = entry_ff[rd_ptr_ff];
   end

endmodule

// File: rtl/rip_back.sv
// ----------------------------------------------------------------------------
// rip_back: column, image store and drain
// CORDIC atan2, column rounding, cell lookup and store, row-major drain walk,
// clearing sweep and the result register.
// ----------------------------------------------------------------------------
module rip_back
   import rip_pkg::*;
#(
   parameter int ROWS = 16,
   parameter int COLS = 1024
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           queue_empty,
   input  rip_item_type   head,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rip_result_type rsp_data
);

   localparam int NCELLS = ROWS * COLS;
   localparam int AW     = $clog2(NCELLS);
   localparam int CPW    = AW + 1;
   localparam int CIW    = $clog2(COLS);
   localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CSW    = CIW + 5;

   localparam logic [CPW-1:0]        CELL_END  = CPW'(NCELLS);
   localparam logic [AW-1:0]         CELL_LAST = AW'(NCELLS - 1);
   localparam logic [AW-1:0]         COLS_A    = AW'(COLS);
   localparam logic [CIW-1:0]        COL_LAST  = CIW'(COLS - 1);
   localparam logic signed [CSW-1:0] COL_HALF  = CSW'(COLS / 2);
   localparam logic signed [CSW-1:0] COL_SPAN  = CSW'(COLS);
   localparam logic signed [T_W-1:0] COLS_T    = T_W'(COLS);
   localparam logic signed [T_W-1:0] QUARTER_T = T_W'(64'sd1073741824);
   localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(64'sd1073741824);
   localparam logic [T_W-1:0]        HALF_LSB  = T_W'(64'h8000_0000);

   rip_back_state_type state_ff, state_in;

   rip_item_type               itm_ff, itm_in;
   logic signed [CORDIC_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ANG_W-1:0]    ang_ff, ang_in;
   logic [4:0]                 it_ff, it_in;
   logic signed [T_W-1:0]      t_ff, t_in;
   logic [CIW-1:0]             col_ff, col_in;
   logic [CPW-1:0]             cursor_ff, cursor_in;
   logic [CIW-1:0]             ccol_ff, ccol_in;
   logic [RW-1:0]              crow_ff, crow_in;
   logic [INDEX_W-1:0]         count_ff, count_in;
   logic [INDEX_W-1:0]         rstart_ff, rstart_in;
   logic [AW-1:0]              clr_ff, clr_in;
   rip_result_type             rsl_ff, rsl_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rip_result_type             rsp_data_ff, rsp_data_in;

   // image store
   logic                       vld_mem [NCELLS];
   logic [DATA_W-1:0]          dat_mem [NCELLS];
   logic                       vld_rd_ff;
   logic [DATA_W-1:0]          dat_rd_ff;
   logic [AW-1:0]              rd_addr, wr_addr;
   logic                       vld_we, vld_wd, dat_we;
   logic [DATA_W-1:0]          dat_wd;

   logic signed [CORDIC_W-1:0] cx0, cy0, xs, ys;
   logic signed [ANG_W-1:0]    tab;
   logic signed [T_W-1:0]      diff_z;
   logic [T_W-1:0]             mag, rnd;
   logic signed [CSW-1:0]      r_s, col_s, col_w;
   logic                       col_bad;
   logic [AW-1:0]              proj_addr;
   logic [INDEX_W-1:0]         rstart_now;
   logic                       send_go;
   rip_result_type             done_rsl;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         ccol_ff      <= '0;
         crow_ff      <= '0;
         count_ff     <= '0;
         rstart_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         ccol_ff      <= ccol_in;
         crow_ff      <= crow_in;
         count_ff     <= count_in;
         rstart_ff    <= rstart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      itm_ff      <= itm_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      ang_ff      <= ang_in;
      it_ff       <= it_in;
      t_ff        <= t_in;
      col_ff      <= col_in;
      rsl_ff      <= rsl_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (vld_we) begin
         vld_mem[wr_addr] <= vld_wd;
      end
      if (dat_we) begin
         dat_mem[wr_addr] <= dat_wd;
      end
      vld_rd_ff <= vld_mem[rd_addr];
      dat_rd_ff <= dat_mem[rd_addr];
   end

   // arithmetic helpers
   always_comb begin
      cx0     = CORDIC_W'($signed(itm_ff.y)) <<< 20;
      cy0     = CORDIC_W'($signed(itm_ff.x)) <<< 20;
      xs      = cx_ff >>> it_ff;
      ys      = cy_ff >>> it_ff;
      tab     = $signed(ANG_W'(ang_step(it_ff)));
      diff_z  = T_W'(ang_ff) - QUARTER_T;
      mag     = t_ff[T_W-1] ? T_W'(-t_ff) : T_W'(t_ff);
      rnd     = (mag + HALF_LSB) >> 32;
      r_s     = CSW'(rnd);
      col_s   = t_ff[T_W-1] ? (COL_HALF + r_s) : (COL_HALF - r_s);
      col_w   = (col_s >= COL_SPAN) ? (col_s - COL_SPAN) : col_s;
      col_bad = col_w[CSW-1] || (col_w >= COL_SPAN);
      proj_addr  = AW'(itm_ff.ring) * COLS_A + AW'(col_ff);
      rstart_now = (ccol_ff == '0) ? count_ff : rstart_ff;
      send_go    = !rsp_valid_ff || rsp_ready;

      done_rsl                  = '0;
      done_rsl.status           = ST_DONE;
      done_rsl.out_index        = count_ff;
      done_rsl.ring_start_index = count_ff + INDEX_W'(4);
      done_rsl.last             = 1'b1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_ff == CELL_LAST) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!queue_empty) begin
               if (head.kind == KIND_DRAIN) begin
                  state_in = (cursor_ff == CELL_END) ? BK_SEND : BK_SCAN;
               end else if (head.status != ST_STORED) begin
                  state_in = BK_SEND;
               end else begin
                  state_in = BK_ROTATE;
               end
            end
         end
         BK_ROTATE: state_in = BK_CORDIC;
         BK_CORDIC: begin
            if (it_ff == CORDIC_LAST) begin
               state_in = BK_SCALE;
            end
         end
         BK_SCALE:  state_in = BK_COLUMN;
         BK_COLUMN: state_in = col_bad ? BK_SEND : BK_LOOKUP;
         BK_LOOKUP: state_in = BK_CHECK;
         BK_CHECK:  state_in = BK_SEND;
         BK_SCAN:   state_in = BK_SCAN_CHK;
         BK_SCAN_CHK: begin
            if (vld_rd_ff || (cursor_ff + CPW'(1) == CELL_END)) begin
               state_in = BK_SEND;
            end else begin
               state_in = BK_SCAN;
            end
         end
         BK_SEND: begin
            if (send_go) begin
               state_in = rsl_ff.last ? BK_CLEAR : BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and store control
   always_comb begin
      itm_in      = itm_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      ang_in      = ang_ff;
      it_in       = it_ff;
      t_in        = t_ff;
      col_in      = col_ff;
      cursor_in   = cursor_ff;
      ccol_in     = ccol_ff;
      crow_in     = crow_ff;
      count_in    = count_ff;
      rstart_in   = rstart_ff;
      clr_in      = clr_ff;
      rsl_in      = rsl_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop     = 1'b0;
      rd_addr = cursor_ff[AW-1:0];
      wr_addr = proj_addr;
      vld_we  = 1'b0;
      vld_wd  = 1'b0;
      dat_we  = 1'b0;
      dat_wd  = {itm_ff.range, itm_ff.x, itm_ff.y, itm_ff.z, itm_ff.intensity};

      case (state_ff)
         BK_CLEAR: begin
            vld_we  = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
         end
         BK_IDLE: begin
            if (!queue_empty) begin
               pop          = 1'b1;
               itm_in       = head;
               rsl_in       = '0;
               rsl_in.range = head.range;
               rsl_in.status = head.status;
               if (head.status == ST_DOWNS) begin
                  rsl_in.row = 4'(head.ring);
               end
               if (head.kind == KIND_DRAIN) begin
                  rsl_in = '0;
                  if (cursor_ff == CELL_END) begin
                     rsl_in    = done_rsl;
                     cursor_in = '0;
                     ccol_in   = '0;
                     crow_in   = '0;
                     count_in  = '0;
                     rstart_in = '0;
                  end
               end
            end
         end
         BK_ROTATE: begin
            it_in = 5'd0;
            if (cx0 < 0) begin
               if (cy0 >= 0) begin
                  cx_in  = cy0;
                  cy_in  = -cx0;
                  ang_in = QUARTER;
               end else begin
                  cx_in  = -cy0;
                  cy_in  = cx0;
                  ang_in = -QUARTER;
               end
            end else begin
               cx_in  = cx0;
               cy_in  = cy0;
               ang_in = '0;
            end
         end
         BK_CORDIC: begin
            it_in = it_ff + 5'd1;
            if (!cy_ff[CORDIC_W-1]) begin
               cx_in  = cx_ff + ys;
               cy_in  = cy_ff - xs;
               ang_in = ang_ff + tab;
            end else begin
               cx_in  = cx_ff - ys;
               cy_in  = cy_ff + xs;
               ang_in = ang_ff - tab;
            end
         end
         BK_SCALE: begin
            t_in = diff_z * COLS_T;
         end
         BK_COLUMN: begin
            col_in = col_w[CIW-1:0];
            if (col_bad) begin
               rsl_in.status = ST_COLUMN;
               rsl_in.row    = 4'(itm_ff.ring);
            end
         end
         BK_LOOKUP: begin
            rd_addr = proj_addr;
         end
         BK_CHECK: begin
            rsl_in.row    = 4'(itm_ff.ring);
            rsl_in.column = 10'(col_ff);
            if (vld_rd_ff) begin
               rsl_in.status = ST_DUP;
            end else begin
               rsl_in.status = ST_STORED;
               vld_we = 1'b1;
               vld_wd = 1'b1;
               dat_we = 1'b1;
            end
         end
         BK_SCAN: begin
            rd_addr = cursor_ff[AW-1:0];
         end
         BK_SCAN_CHK: begin
            rstart_in = rstart_now;
            cursor_in = cursor_ff + CPW'(1);
            if (ccol_ff == COL_LAST) begin
               ccol_in = '0;
               crow_in = crow_ff + RW'(1);
            end else begin
               ccol_in = ccol_ff + CIW'(1);
            end
            if (vld_rd_ff) begin
               rsl_in                  = '0;
               rsl_in.status           = ST_EXTRACT;
               rsl_in.row              = 4'(crow_ff);
               rsl_in.column           = 10'(ccol_ff);
               rsl_in.range            = dat_rd_ff[DATA_W-1 -: RANGE_W];
               rsl_in.out_x            = dat_rd_ff[INTEN_W+3*COORD_W-1 -: COORD_W];
               rsl_in.out_y            = dat_rd_ff[INTEN_W+2*COORD_W-1 -: COORD_W];
               rsl_in.out_z            = dat_rd_ff[INTEN_W+COORD_W-1 -: COORD_W];
               rsl_in.out_intensity    = dat_rd_ff[INTEN_W-1:0];
               rsl_in.out_index        = count_ff;
               rsl_in.ring_start_index = rstart_now + INDEX_W'(4);
               count_in = count_ff + INDEX_W'(1);
            end else if (cursor_ff + CPW'(1) == CELL_END) begin
               rsl_in    = done_rsl;
               cursor_in = '0;
               ccol_in   = '0;
               crow_in   = '0;
               count_in  = '0;
               rstart_in = '0;
            end
         end
         BK_SEND: begin
            if (send_go) begin
               rsp_data_in  = rsl_ff;
               rsp_valid_in = 1'b1;
               clr_in       = '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/range_image_projector.sv
// ----------------------------------------------------------------------------
// range_image_projector: lidar point to range image projection
// Projects points into a ROWS x COLS image and drains filled cells in order.
// ----------------------------------------------------------------------------
// A project beat (req_kind 0) gives one result: its range is the integer
// root of x^2+y^2+z^2, then it is rejected on range, ring or downsampling,
// or its column is worked out from a 30-step CORDIC atan2 and the point is
// stored unless the column is out of range or the cell is taken. The intake
// does three squares and a 26-step bit-serial root; the back end does the
// CORDIC iterations, column rounding and the store read and write. The two
// overlap through a two-entry queue, so the intake can take the next point
// while the back end works. A drain beat (req_kind 1) walks the store in
// row-major order from where the last drain stopped and returns the next
// filled cell; once none is left it returns a done result (last 1, out_index
// = total count) and the store is then swept clear, one cell a cycle, over
// all ROWS*COLS cells (16384 at the default size). The same sweep runs after
// reset. Points are still taken into the queue during a sweep. The
// csr port is always ready and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module range_image_projector
   import rip_pkg::*;
#(
   parameter int ROWS = 16,
   parameter int COLS = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   // point and drain beats
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic signed [COORD_W-1:0] req_x,
   input  logic signed [COORD_W-1:0] req_y,
   input  logic signed [COORD_W-1:0] req_z,
   input  logic [INTEN_W-1:0]        req_intensity,
   input  logic [RING_W-1:0]         req_ring,
   // results
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_status,
   output logic [3:0]                rsp_row,
   output logic [9:0]                rsp_column,
   output logic [RANGE_W-1:0]        rsp_range,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic signed [COORD_W-1:0] rsp_out_z,
   output logic [INTEN_W-1:0]        rsp_out_intensity,
   output logic [INDEX_W-1:0]        rsp_out_index,
   output logic [INDEX_W-1:0]        rsp_ring_start_index,
   output logic                      rsp_last,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [RANGE_W-1:0]        csr_wdata
);

   logic [RANGE_W-1:0] min_range_ff, max_range_ff;
   logic [4:0]         rate_ff;

   logic           push_valid, queue_full, queue_empty, pop;
   rip_item_type   push_item, head;
   rip_result_type rsp_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff <= RANGE_W'(256);
         max_range_ff <= RANGE_W'(256000);
         rate_ff      <= 5'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_RANGE:  min_range_ff <= csr_wdata;
            CSR_MAX_RANGE:  max_range_ff <= csr_wdata;
            CSR_DOWNSAMPLE: rate_ff      <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // intake: range, ring and downsample checks
   rip_front #(
      .ROWS (ROWS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_x           (req_x),
      .req_y           (req_y),
      .req_z           (req_z),
      .req_intensity   (req_intensity),
      .req_ring        (req_ring),
      .min_range       (min_range_ff),
      .max_range       (max_range_ff),
      .downsample_rate (rate_ff),
      .push_valid      (push_valid),
      .push_item       (push_item),
      .queue_full      (queue_full)
   );

   rip_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head       (head)
   );

   // column, image store, drain and result register
   rip_back #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   assign rsp_status           = rsp_data.status;
   assign rsp_row              = rsp_data.row;
   assign rsp_column           = rsp_data.column;
   assign rsp_range            = rsp_data.range;
   assign rsp_out_x            = rsp_data.out_x;
   assign rsp_out_y            = rsp_data.out_y;
   assign rsp_out_z            = rsp_data.out_z;
   assign rsp_out_intensity    = rsp_data.out_intensity;
   assign rsp_out_index        = rsp_data.out_index;
   assign rsp_ring_start_index = rsp_data.ring_start_index;
   assign rsp_last             = rsp_data.last;

endmodule
